### src/sm3_hash_engine_core_defines.svh
// Assertion macros for the SM3 hash engine
`ifndef SM3_HASH_ENGINE_CORE_DEFINES_SVH
`define SM3_HASH_ENGINE_CORE_DEFINES_SVH
// assert that a condition implies a consequence on the same edge
`define SM3_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("sm3 check failed");
// assert that a condition implies a consequence on the next edge
`define SM3_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("sm3 check failed");
`endif

### src/sm3_pkg.sv
// ----------------------------------------------------------------------------
// sm3_pkg
// Types, constants and round functions shared by the SM3 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package sm3_pkg;
	localparam logic [31:0] T_LOW  = 32'h79CC4519;
	localparam logic [31:0] T_HIGH = 32'h7A879D8A;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [255:0] IV = {32'h7380166F, 32'h4914B2B9, 32'h172442D7,
		32'hDA8A0600, 32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E};

	// control from sequencer to round unit
	typedef struct packed {
		logic       load;   // load working vars from chaining value
		logic       round;  // perform one round
		logic [5:0] j;      // round number
		logic       fold;   // xor working vars into chaining value
		logic       init;   // reset chaining value to IV
	} rnd_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction
	function automatic logic [31:0] p0(input logic [31:0] x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction
	function automatic logic [31:0] p1(input logic [31:0] x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction
endpackage

### src/sm3_round.sv
// ----------------------------------------------------------------------------
// sm3_round
// Message schedule window and the shared compression round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sm3_round (
	input  logic              clk,
	input  logic              arst_n,
	input  sm3_pkg::rnd_ctl_t ctl,
	input  logic [511:0]      block,
	output logic [255:0]      cv
);
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [255:0] cv_q;
	logic [31:0] wn, a12, t, ss1, ss2, ff, gg, tt1, tt2;

	// next schedule word, w[j+16]
	assign wn = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
		^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];

	// one round
	always_comb begin
		a12 = sm3_pkg::rotl(v_q[0], 5'd12);
		t   = (ctl.j < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
		ss1 = sm3_pkg::rotl(a12 + v_q[4] + sm3_pkg::rotl(t, ctl.j[4:0]), 5'd7);
		ss2 = ss1 ^ a12;
		if (ctl.j < 6'd16) begin
			ff = v_q[0] ^ v_q[1] ^ v_q[2];
			gg = v_q[4] ^ v_q[5] ^ v_q[6];
		end else begin
			ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
			gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
		end
		tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
		tt2 = gg + v_q[7] + ss1 + w_q[0];
	end

	// working registers and schedule window
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511-32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= cv_q[255-32*i -: 32];
		end else if (ctl.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[0] <= tt1; v_q[1] <= v_q[0];
			v_q[2] <= sm3_pkg::rotl(v_q[1], 5'd9); v_q[3] <= v_q[2];
			v_q[4] <= sm3_pkg::p0(tt2); v_q[5] <= v_q[4];
			v_q[6] <= sm3_pkg::rotl(v_q[5], 5'd19); v_q[7] <= v_q[6];
		end
	end

	// chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= sm3_pkg::IV;
		end else if (ctl.init) begin
			cv_q <= sm3_pkg::IV;
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) cv_q[255-32*i -: 32] <= cv_q[255-32*i -: 32] ^ v_q[i];
		end
	end
	assign cv = cv_q;
endmodule

### src/sm3_hash_engine_core.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine_core
// Streaming SM3 hash engine with a byte input and a word digest output.
// ----------------------------------------------------------------------------
// Input channel: one item per byte (data_byte, byte_present, end_of_message),
// valid/ready handshake. A byte item that does not fill the block leaves
// in_ready high. The 64th byte starts a compression: a load, the rounds and
// a fold through the single shared round unit, during which in_ready is low.
// An item with end_of_message appends padding (one byte per cycle into the
// buffer) and compresses one or two final blocks, then presents eight digest
// words, word 0 first, on the output channel. A stalled receiver holds the
// current word; the input stays closed until word 7 is taken, after which the
// chaining value returns to the IV.
// Reset (arst_n low) restores the IV, empties the buffer and clears the bit
// count. The block buffer has no reset; padding writes every byte read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sm3_hash_engine_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_number,
	output logic        last_word
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001, S_LOAD = 6'b000010, S_RND = 6'b000100,
		S_FOLD = 6'b001000, S_PAD = 6'b010000, S_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [511:0] buf_q;   // byte shift register, oldest byte at the top
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [5:0]  rnd_q;
	logic        fin_q;    // message closed, padding in progress
	logic        lenw_q;   // this block carries the length
	logic        pad_open_q;
	logic [2:0]  wn_q;
	logic [511:0] block;
	logic [255:0] cv;
	sm3_pkg::rnd_ctl_t ctl;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;

	// block view of the buffer, length in last 8 bytes when required
	assign block = lenw_q ? {buf_q[447:0], bits_q} : buf_q;

	always_comb begin
		ctl.load  = (state_q == S_LOAD);
		ctl.round = (state_q == S_RND);
		ctl.j     = rnd_q;
		ctl.fold  = (state_q == S_FOLD);
		ctl.init  = (state_q == S_OUT) && out_ready && (wn_q == 3'd7);
	end

	sm3_round u_round (.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(block), .cv(cv));

	// buffer shifts: data bytes, then pad/zero bytes
	always_ff @(posedge clk) begin
		if (acc && byte_present) buf_q <= {buf_q[503:0], data_byte};
		else if (acc && end_of_message) buf_q <= {buf_q[503:0], sm3_pkg::PAD_BYTE};
		else if (state_q == S_PAD)
			buf_q <= {buf_q[503:0], pad_open_q ? sm3_pkg::PAD_BYTE : 8'h00};
	end

	// 0x80 still owed after a data byte that closed the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pad_open_q <= 1'b0;
		else if (acc) pad_open_q <= byte_present && end_of_message;
		else if (state_q == S_PAD) pad_open_q <= 1'b0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0; bits_q <= '0; rnd_q <= '0;
			fin_q <= 1'b0; lenw_q <= 1'b0; wn_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (byte_present) begin
							bits_q <= bits_q + 64'd8;
							fill_q <= fill_q + 6'd1;
							if (end_of_message) begin
								fin_q <= 1'b1;
								state_q <= (fill_q == 6'd63) ? S_LOAD : S_PAD;
							end else if (fill_q == 6'd63) begin
								state_q <= S_LOAD;
							end
						end else if (end_of_message) begin
							// pad byte written this cycle
							fin_q <= 1'b1;
							if (fill_q == 6'd55) begin
								// pad byte ends the data area, length fits here
								lenw_q <= 1'b1;
								fill_q <= '0;
								state_q <= S_LOAD;
							end else begin
								fill_q <= fill_q + 6'd1;
								state_q <= (fill_q == 6'd63) ? S_LOAD : S_PAD;
							end
						end
					end
				end
				S_PAD: begin
					// zero fill; a data byte ending the message still needs its 0x80 first
					if (fill_q == 6'd55) begin
						lenw_q <= 1'b1;
						state_q <= S_LOAD;
						fill_q <= '0;
					end else begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					rnd_q <= '0;
					state_q <= S_RND;
				end
				S_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= S_FOLD;
				end
				S_FOLD: begin
					fill_q <= '0;
					if (lenw_q) begin
						lenw_q <= 1'b0; wn_q <= '0; state_q <= S_OUT;
					end else if (fin_q) state_q <= S_PAD;
					else state_q <= S_IDLE;
				end
				S_OUT: begin
					if (out_ready) begin
						wn_q <= wn_q + 3'd1;
						if (wn_q == 3'd7) begin
							state_q <= S_IDLE; bits_q <= '0; fin_q <= 1'b0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = (state_q == S_OUT);
	assign digest_word = cv[255 - 32*wn_q -: 32];
	assign word_number = wn_q;
	assign last_word   = (wn_q == 3'd7);
endmodule

### src/sm3_hash_engine_core_chk.sv
// ----------------------------------------------------------------------------
// sm3_hash_engine_core_chk
// Port-level checks for the SM3 hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sm3_hash_engine_core_defines.svh"
module sm3_hash_engine_core_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_number,
	input logic        last_word
);
	`SM3_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`SM3_ASSERT_IMP(a_last_pos, clk, arst_n, out_valid, last_word == (word_number == 3'd7))
	`SM3_ASSERT_NXT(a_word_step, clk, arst_n, out_valid && out_ready && !last_word,
		out_valid && word_number == $past(word_number) + 3'd1)
	`SM3_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(digest_word))
endmodule

bind sm3_hash_engine_core sm3_hash_engine_core_chk u_chk (.*);
